// File: hw/rtl/slr_pkg.sv
// Shared types and constants of the stereo linear resampler.
package slr_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int POS_W        = 24;
   localparam int FRAC_W       = 16;
   localparam int DEF_MAX_UPSAMPLE = 16;
   localparam int IN_DEPTH     = 2;
   localparam int OUT_DEPTH    = 4;

   localparam logic [POS_W-1:0] ONE_Q16      = 24'h010000;
   localparam logic [POS_W-1:0] POS_MAX      = 24'hFFFFFF;
   localparam logic [POS_W-1:0] STEP_RESET   = 24'h010000;

   // One stereo input frame.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } frame_type;

   // One interpolated result.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
   } result_type;

endpackage

// File: hw/rtl/slr_front.sv
// Input frame queue of the stereo linear resampler.
module slr_front
   import slr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  frame_type  push_frame,
   output frame_type  head_frame,
   output logic       head_valid,
   input  logic       head_pop
);

   localparam int PW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
   localparam int CW = $clog2(IN_DEPTH + 1);

   frame_type         queue_ff [IN_DEPTH];
   logic [PW-1:0]     wptr_ff, wptr_in;
   logic [PW-1:0]     rptr_ff, rptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_write, do_read;

   assign full       = (count_ff == CW'(IN_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_frame = queue_ff[rptr_ff];
   assign do_write   = push && !full;
   assign do_read    = head_pop && head_valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_write) begin
         wptr_in = (wptr_ff == PW'(IN_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_read) begin
         rptr_in = (rptr_ff == PW'(IN_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (!do_write && do_read) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         queue_ff[wptr_ff] <= push_frame;
      end
   end

endmodule

// File: hw/rtl/slr_back.sv
// Interpolation engine and result queue of the stereo linear resampler.
module slr_back
   import slr_pkg::*;
#(
   parameter int MAX_UPSAMPLE = DEF_MAX_UPSAMPLE
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_we,
   input  logic [POS_W-1:0]  step_data,
   input  frame_type         head_frame,
   input  logic              head_valid,
   output logic              head_pop,
   output logic              empty,
   input  logic              pop,
   output result_type        result
);

   localparam int CW  = $clog2(MAX_UPSAMPLE + 1);
   localparam int PW  = $clog2(OUT_DEPTH);
   localparam int OCW = $clog2(OUT_DEPTH + 1);
   localparam int PRODW = 2 * (SAMPLE_W + 1);

   // Position, step and held frame.
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [POS_W-1:0]          step_ff;
   logic signed [SAMPLE_W-1:0] held_l_ff, held_r_ff;
   logic [CW-1:0]             cnt_ff, cnt_in;

   // Product stage.
   logic                      p1_valid_ff;
   logic signed [PRODW-1:0]   prod_l_ff, prod_r_ff;
   logic signed [SAMPLE_W-1:0] prev_l_ff, prev_r_ff;
   logic                      p1_last_ff;

   // Result queue.
   result_type                rq_ff [OUT_DEPTH];
   logic [PW-1:0]             rq_wptr_ff, rq_rptr_ff;
   logic [OCW-1:0]            rq_count_ff;

   logic                      below_one, at_cap, has_space;
   logic                      issue, finish_only, last;
   logic [POS_W:0]            pos_sum;
   logic [POS_W-1:0]          next_pos;
   logic signed [SAMPLE_W:0]  pos_s, diff_l, diff_r;
   logic signed [PRODW-1:0]   prod_l, prod_r;
   logic signed [SAMPLE_W-1:0] out_l, out_r;
   logic                      rq_read;

   function automatic logic [POS_W-1:0] sub_one(input logic [POS_W-1:0] p);
      logic [POS_W-1:0] r;
      r = (p >= ONE_Q16) ? p - ONE_Q16 : '0;
      return r;
   endfunction

   // Truncate the scaled product toward zero and add it to the held sample.
   function automatic logic signed [SAMPLE_W-1:0] finish_lerp(
      input logic signed [PRODW-1:0]    prod,
      input logic signed [SAMPLE_W-1:0] prev
   );
      logic signed [PRODW-1:0]      bias;
      logic signed [PRODW-1:0]      adj;
      logic signed [PRODW-FRAC_W-1:0] t;
      logic signed [PRODW-FRAC_W-1:0] s;
      bias = prod[PRODW-1] ? PRODW'((1 << FRAC_W) - 1) : '0;
      adj  = prod + bias;
      t    = adj[PRODW-1:FRAC_W];
      s    = t + (PRODW-FRAC_W)'(prev);
      return s[SAMPLE_W-1:0];
   endfunction

   assign below_one = (pos_ff < ONE_Q16);
   assign at_cap    = (cnt_ff == CW'(MAX_UPSAMPLE));
   assign has_space = ({1'b0, rq_count_ff} + (OCW+1)'(p1_valid_ff)) < (OCW+1)'(OUT_DEPTH);

   assign pos_sum  = {1'b0, pos_ff} + {1'b0, step_ff};
   assign next_pos = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

   assign issue       = head_valid && below_one && !at_cap && has_space;
   assign finish_only = head_valid && (!below_one || at_cap);
   assign last        = (next_pos >= ONE_Q16) || (cnt_ff == CW'(MAX_UPSAMPLE - 1));
   assign head_pop    = (issue && last) || finish_only;

   assign pos_s  = {1'b0, pos_ff[FRAC_W-1:0]};
   assign diff_l = {head_frame.left[SAMPLE_W-1], head_frame.left}
                 - {held_l_ff[SAMPLE_W-1], held_l_ff};
   assign diff_r = {head_frame.right[SAMPLE_W-1], head_frame.right}
                 - {held_r_ff[SAMPLE_W-1], held_r_ff};
   assign prod_l = pos_s * diff_l;
   assign prod_r = pos_s * diff_r;

   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (issue) begin
         if (last) begin
            pos_in = sub_one(next_pos);
            cnt_in = '0;
         end else begin
            pos_in = next_pos;
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (finish_only) begin
         pos_in = sub_one(pos_ff);
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         step_ff     <= STEP_RESET;
         held_l_ff   <= '0;
         held_r_ff   <= '0;
         cnt_ff      <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         p1_valid_ff <= issue;
         if (step_we) begin
            step_ff <= step_data;
         end
         if (head_pop) begin
            held_l_ff <= head_frame.left;
            held_r_ff <= head_frame.right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_l_ff  <= prod_l;
         prod_r_ff  <= prod_r;
         prev_l_ff  <= held_l_ff;
         prev_r_ff  <= held_r_ff;
         p1_last_ff <= last;
      end
   end

   assign out_l = finish_lerp(prod_l_ff, prev_l_ff);
   assign out_r = finish_lerp(prod_r_ff, prev_r_ff);

   // Result queue; issue is held back so a product in flight always has a slot.
   assign empty   = (rq_count_ff == '0);
   assign result  = rq_ff[rq_rptr_ff];
   assign rq_read = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wptr_ff  <= '0;
         rq_rptr_ff  <= '0;
         rq_count_ff <= '0;
      end else begin
         if (p1_valid_ff) begin
            rq_wptr_ff <= rq_wptr_ff + 1'b1;
         end
         if (rq_read) begin
            rq_rptr_ff <= rq_rptr_ff + 1'b1;
         end
         if (p1_valid_ff && !rq_read) begin
            rq_count_ff <= rq_count_ff + 1'b1;
         end else if (!p1_valid_ff && rq_read) begin
            rq_count_ff <= rq_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         rq_ff[rq_wptr_ff] <= '{left: out_l, right: out_r, last: p1_last_ff};
      end
   end

endmodule

// File: hw/rtl/stereo_linear_resampler.sv
// Top level of the stereo linear resampler: frame queue, interpolation engine, checks.
//
//   Channel   Direction  Handshake           Payload
//   req_      in         req_push/req_full   req_left_sample, req_right_sample
//   rsp_      out        rsp_pop/rsp_empty   rsp_left_out, rsp_right_out, rsp_last_of_run
//   csr_      in         csr_write_enable    csr_write_data (phase step, Q8.16)
//
// The engine produces one result per cycle while a frame waits and the result queue has
// room; a frame holds the head of the frame queue until its last result is issued. A
// result reaches the rsp_ ports via the product register (multiply) and the result
// queue (truncate and add). Reset is synchronous and leaves both queues empty and the
// position at zero; no clearing pass follows. When the result queue fills, issue stops,
// and the two-entry frame queue keeps accepting until it is full as well.
module stereo_linear_resampler
   import slr_pkg::*;
#(
   parameter int MAX_UPSAMPLE = DEF_MAX_UPSAMPLE
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_left_sample,
   input  logic signed [SAMPLE_W-1:0] req_right_sample,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_last_of_run,
   input  logic                       csr_write_enable,
   input  logic [POS_W-1:0]           csr_write_data
);

   frame_type    in_frame;
   frame_type    head_frame;
   logic         head_valid;
   logic         head_pop;
   result_type   result;

   assign in_frame = '{left: req_left_sample, right: req_right_sample};

   // The front side only queues incoming frames, so the sender waits only when the frame queue is full.
   slr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .push_frame (in_frame),
      .head_frame (head_frame),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // The back side walks the read position across the held and the head frame.
   slr_back #(
      .MAX_UPSAMPLE (MAX_UPSAMPLE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .step_we    (csr_write_enable),
      .step_data  (csr_write_data),
      .head_frame (head_frame),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .empty      (rsp_empty),
      .pop        (rsp_pop),
      .result     (result)
   );

   assign rsp_left_out    = result.left;
   assign rsp_right_out   = result.right;
   assign rsp_last_of_run = result.last;

   // The engine retires a frame only when one is waiting.
   a_pop_needs_frame: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("frame retired from an empty frame queue");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // Reset leaves room for a new frame.
   a_reset_room: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("frame queue full after reset");

endmodule
